// ===== rtl/stln_pkg.sv =====
// shared types and character constants for the source text line normaliser
// no dependencies
package stln_pkg;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	// output queue depth and index widths
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		BRK_NONE = 2'd0,
		BRK_LF   = 2'd1,
		BRK_CR   = 2'd2
	} brk_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_t;

	typedef struct packed {
		logic string_mode;
		logic comment_mode;
		brk_t held_break;
		logic after_newline;
	} norm_st_t;

	// results of one input beat: up to two bytes
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       last;
	} step_t;

endpackage

// ===== rtl/source_text_line_normalizer.sv =====
// top level of the source text line normaliser
// depends on stln_pkg, stln_norm and stln_obuf
//
// raw channel: one text byte per beat (in_byte, in_last), valid/stall.
// clean channel: normalised bytes, one per beat, out_last on the final byte
// of a text. Each raw beat gives zero, one or two clean beats.
// A raw beat is registered, then the normalising logic runs on it together
// with the mode flags and writes its results into a four-entry queue that
// drives the clean channel straight from its entries.
// Path: the input register beat_s1, then the entries of the result queue.
// Throughput: one raw beat per cycle while each gives at most one result
// and the clean channel does not stall; beats giving two results are held
// back by the single read port of the result queue.
// A stall on the clean channel fills the queue; raw_stall rises once the
// queue cannot take two more beats behind the registered byte.
// Reset clears the mode flags, the held line break and the queue.
// After a beat with in_last set all mode state returns to its reset values.
module source_text_line_normalizer import stln_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic raw_valid,
	output logic raw_stall,
	input  in_t  raw_beat,
	output logic clean_valid,
	input  logic clean_stall,
	output out_t clean_beat
);

	logic  valid_s1;
	in_t   beat_s1;
	logic  room;
	logic  fire;
	step_t res;

	assign fire      = valid_s1 && room;
	assign raw_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!raw_stall) begin
			valid_s1 <= raw_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!raw_stall && raw_valid) begin
			beat_s1 <= raw_beat;
		end
	end

	stln_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.beat   (beat_s1),
		.res    (res)
	);

	stln_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.res    (res),
		.room   (room),
		.valid  (clean_valid),
		.stall  (clean_stall),
		.data   (clean_beat)
	);

endmodule

// ===== rtl/stln_norm.sv =====
// per-beat normalising logic and the string / comment / line-break state
// depends on stln_pkg
module stln_norm import stln_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  in_t        beat,
	output step_t      res
);

	norm_st_t st_q;
	norm_st_t st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{string_mode: 1'b0, comment_mode: 1'b0,
			          held_break: BRK_NONE, after_newline: 1'b0};
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic       pair;
		logic       do_handle;
		logic       emit;
		logic [7:0] ebyte;
		logic [1:0] n;
		logic [7:0] o0;
		logic [7:0] o1;
		norm_st_t   s;

		b         = beat.in_byte;
		s         = st_q;
		n         = 2'd0;
		o0        = CH_LF;
		o1        = CH_LF;
		emit      = 1'b0;
		ebyte     = b;
		do_handle = 1'b1;
		pair      = 1'b0;

		// a held break either pairs with this byte or is let out first
		if (s.held_break != BRK_NONE) begin
			pair = (s.held_break == BRK_LF) ? (b == CH_CR) : (b == CH_LF);
			s.held_break    = BRK_NONE;
			s.after_newline = 1'b1;
			if (pair) begin
				n         = 2'd2;
				o0        = CH_SPACE;
				o1        = CH_LF;
				do_handle = 1'b0;
			end else begin
				n  = 2'd1;
				o0 = CH_LF;
			end
		end

		if (do_handle) begin
			if (s.comment_mode && b != CH_LF) begin
				emit            = 1'b1;
				ebyte           = CH_SPACE;
				s.after_newline = 1'b0;
			end else begin
				s.comment_mode = 1'b0;
				if (b == CH_QUOTE) begin
					s.string_mode = ~s.string_mode;
				end
				priority if (s.string_mode) begin
					emit            = 1'b1;
					s.after_newline = 1'b0;
				end else if (b == CH_LF || b == CH_CR) begin
					s.held_break = (b == CH_LF) ? BRK_LF : BRK_CR;
				end else if ((s.after_newline && b == CH_STAR) || b == CH_SEMI) begin
					s.comment_mode  = 1'b1;
					emit            = 1'b1;
					ebyte           = CH_SPACE;
					s.after_newline = 1'b0;
				end else begin
					emit            = 1'b1;
					s.after_newline = 1'b0;
				end
			end
			if (emit) begin
				if (n == 2'd0) begin
					o0 = ebyte;
				end else begin
					o1 = ebyte;
				end
				n = n + 2'd1;
			end
		end

		// end of text flushes a held break and returns to the reset state
		if (beat.in_last) begin
			if (s.held_break != BRK_NONE) begin
				if (n == 2'd0) begin
					o0 = CH_LF;
				end else begin
					o1 = CH_LF;
				end
				n = n + 2'd1;
			end
			s = '{string_mode: 1'b0, comment_mode: 1'b0,
			      held_break: BRK_NONE, after_newline: 1'b0};
		end

		st_d      = s;
		res.cnt   = n;
		res.byte0 = o0;
		res.byte1 = o1;
		res.last  = beat.in_last;
	end

endmodule

// ===== rtl/stln_obuf.sv =====
// small result queue: takes up to two beats per cycle, gives one per cycle while not stalled
// depends on stln_pkg
module stln_obuf import stln_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  step_t res,
	output logic  room,
	output logic  valid,
	input  logic  stall,
	output out_t  data
);

	out_t             mem [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;
	logic             pop;
	logic [1:0]       nwr;
	logic [QAW-1:0]   wr1;
	out_t             e0;
	out_t             e1;

	assign valid = (cnt_q != '0);
	assign data  = mem[rd_q];
	assign pop   = valid && !stall;
	// room for two more beats once this cycle's pop is counted
	assign room  = ({1'b0, cnt_q} - {{QCW{1'b0}}, pop}) <= (QCW + 1)'(QDEPTH - 2);
	assign nwr   = push ? res.cnt : 2'd0;
	assign wr1   = wr_q + QAW'(1);
	assign e0    = '{out_byte: res.byte0, out_last: res.last && res.cnt == 2'd1};
	assign e1    = '{out_byte: res.byte1, out_last: res.last};

	always_ff @(posedge clk) begin
		if (nwr != 2'd0) begin
			mem[wr_q] <= e0;
		end
		if (nwr == 2'd2) begin
			mem[wr1] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QAW'(nwr);
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			cnt_q <= cnt_q + QCW'(nwr) - QCW'(pop);
		end
	end

endmodule

// ===== test/source_text_line_normalizer_test.sv =====
// self-checking testbench for source_text_line_normalizer
// depends on stln_pkg and the rtl of the block; predicts every clean beat from the raw beats
module source_text_line_normalizer_test;
	import stln_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_TOTAL = 950;

	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic raw_valid = 1'b0;
	logic raw_stall;
	in_t  raw_beat = '0;
	logic clean_valid;
	logic clean_stall = 1'b0;
	out_t clean_beat;

	source_text_line_normalizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.raw_valid   (raw_valid),
		.raw_stall   (raw_stall),
		.raw_beat    (raw_beat),
		.clean_valid (clean_valid),
		.clean_stall (clean_stall),
		.clean_beat  (clean_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// normaliser state as predicted
	logic       in_string;
	logic       blanking;
	logic       after_break;
	brk_t       held;
	logic [7:0] step_out [2];
	int         step_n;

	out_t pending_clean [$];
	int   err_count = 0;
	int   beats_sent = 0;
	int   burst_left = 0;
	int   hold_asked = 0;
	int   hold_done = 0;
	int   hold_left = 0;
	int   mode_left = 0;
	int   quiet_cycles = 0;
	rx_mode_t rx_mode = RX_FREE;

	function automatic void clear_text_state();
		in_string   = 1'b0;
		blanking    = 1'b0;
		after_break = 1'b0;
		held        = BRK_NONE;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		if (step_n < 2) begin
			step_out[step_n] = b;
			step_n++;
		end
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		if (blanking) begin
			if (b != CH_LF) begin
				put_byte(CH_SPACE);
				after_break = 1'b0;
				return;
			end
			blanking = 1'b0;
		end
		if (b == CH_QUOTE)
			in_string = ~in_string;
		if (in_string) begin
			put_byte(b);
			after_break = 1'b0;
			return;
		end
		if (b == CH_LF) begin
			held = BRK_LF;
			return;
		end
		if (b == CH_CR) begin
			held = BRK_CR;
			return;
		end
		if ((after_break && b == CH_STAR) || b == CH_SEMI) begin
			blanking = 1'b1;
			put_byte(CH_SPACE);
		end else begin
			put_byte(b);
		end
		after_break = 1'b0;
	endfunction

	function automatic void predict_clean(input in_t beat);
		logic [7:0] b;
		logic       pair;
		out_t       r;
		b = beat.in_byte;
		step_n = 0;
		if (held != BRK_NONE) begin
			// anything held other than lf counts as a held cr
			if (held == BRK_LF)
				pair = (b == CH_CR);
			else
				pair = (b == CH_LF);
			held = BRK_NONE;
			after_break = 1'b1;
			if (pair) begin
				put_byte(CH_SPACE);
				put_byte(CH_LF);
			end else begin
				put_byte(CH_LF);
				take_byte(b);
			end
		end else begin
			take_byte(b);
		end
		if (beat.in_last) begin
			if (held != BRK_NONE) begin
				held = BRK_NONE;
				put_byte(CH_LF);
			end
			clear_text_state();
		end
		for (int i = 0; i < step_n; i++) begin
			r.out_byte = step_out[i];
			r.out_last = beat.in_last && (i == step_n - 1);
			pending_clean.push_back(r);
		end
	endfunction

	// predict on accepted raw beats first, then check accepted clean beats
	always @(posedge clk) begin : watch_beats
		out_t want;
		if (arst_n) begin
			if (raw_valid && !raw_stall)
				predict_clean(raw_beat);
			if (clean_valid && !clean_stall) begin
				if (pending_clean.size() == 0) begin
					$display("%0t: unexpected clean beat byte %h last %b", $time,
						clean_beat.out_byte, clean_beat.out_last);
					err_count++;
				end else begin
					want = pending_clean.pop_front();
					if (clean_beat.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %h actual %h", $time,
							want.out_byte, clean_beat.out_byte);
						err_count++;
					end
					if (clean_beat.out_last !== want.out_last) begin
						$display("%0t: out_last expected %b actual %b", $time,
							want.out_last, clean_beat.out_last);
						err_count++;
					end
				end
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_done != hold_asked) begin
			hold_done   <= hold_asked;
			hold_left   <= HOLD_CYCLES;
			clean_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left   <= hold_left - 1;
			clean_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(16, 160);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_FREE:  clean_stall <= 1'b0;
				RX_LIGHT: clean_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: clean_stall <= ($urandom_range(0, 3) != 0);
				default:  clean_stall <= ~clean_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (raw_valid && !raw_stall) || (clean_valid && !clean_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("source_text_line_normalizer verification failed");
			$finish;
		end
	end

	// offers one beat and returns at the edge that takes it
	task automatic send_text_byte(input logic [7:0] b, input logic last);
		in_t beat;
		int  gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				raw_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		beat.in_byte = b;
		beat.in_last = last;
		raw_valid <= 1'b1;
		raw_beat  <= beat;
		@(posedge clk);
		while (raw_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 8'($urandom_range(33, 126));
		else if (r < 45)
			return CH_SPACE;
		else if (r < 55)
			return CH_LF;
		else if (r < 63)
			return CH_CR;
		else if (r < 71)
			return CH_QUOTE;
		else if (r < 79)
			return CH_SEMI;
		else if (r < 87)
			return CH_STAR;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_extreme_bytes();
		send_text_byte(8'h00, 1'b0);
		send_text_byte(8'hFF, 1'b1);
	endtask

	// pairs both ways, repeated breaks, a break before a plain byte, a flush on last
	task automatic test_line_breaks();
		send_text_byte(CH_CR, 1'b0);
		send_text_byte(CH_LF, 1'b0);
		send_text_byte(CH_LF, 1'b0);
		send_text_byte(CH_CR, 1'b0);
		send_text_byte(CH_LF, 1'b0);
		send_text_byte(CH_LF, 1'b0);
		send_text_byte(CH_CR, 1'b0);
		send_text_byte(CH_CR, 1'b0);
		send_text_byte("x", 1'b0);
		send_text_byte(CH_LF, 1'b1);
	endtask

	task automatic test_strings();
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(CH_CR, 1'b0);
		send_text_byte(CH_SEMI, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte("a", 1'b1);
	endtask

	// semicolon blanking over quote and cr, then a star at line start
	task automatic test_comments();
		send_text_byte(CH_SEMI, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(CH_CR, 1'b0);
		send_text_byte(CH_LF, 1'b0);
		send_text_byte(CH_STAR, 1'b0);
		send_text_byte("b", 1'b0);
		send_text_byte(CH_LF, 1'b0);
		send_text_byte(CH_STAR, 1'b1);
	endtask

	// receiver holds off while the sender keeps offering, so the block fills
	task automatic test_output_hold();
		hold_asked++;
		burst_left = 60;
		for (int i = 0; i < 40; i++)
			send_text_byte(pick_text_byte(), i == 39);
	endtask

	task automatic test_random_text();
		int len;
		while (beats_sent < RANDOM_TOTAL) begin
			len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
			for (int i = 0; i < len; i++)
				send_text_byte(pick_text_byte(), i == len - 1);
		end
	endtask

	initial begin
		clear_text_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_bytes();
		test_line_breaks();
		test_strings();
		test_comments();
		test_output_hold();
		test_random_text();
		raw_valid <= 1'b0;
		while (pending_clean.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("source_text_line_normalizer verification clean");
		else
			$display("source_text_line_normalizer verification failed");
		$finish;
	end

endmodule
